// ===== hdl/rgb2hsv_pkg.sv =====
`timescale 1ns / 1ps

package rgb2hsv_pkg;

  // fixed field widths
  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 13;
  localparam int VAL_W = 8;

  // default fraction bits of hue and saturation
  localparam int HUE_FRAC_DEF = 12;
  localparam int SAT_FRAC_DEF = 12;

  // hue sector, chosen by the channel holding the maximum
  typedef logic [1:0] sector_t;
  localparam sector_t SEC_RED   = 2'd0;
  localparam sector_t SEC_GREEN = 2'd1;
  localparam sector_t SEC_BLUE  = 2'd2;

  typedef logic [CH_W-1:0] chan_t;

endpackage

// ===== hdl/rgb_to_hsv_convert.sv =====
`timescale 1ns / 1ps

// rgb to hsv converter with change detection
//
// input channel: in_valid / in_ready carries one 8-bit red, green, blue sample
// output channel: out_valid / out_ready carries hue, saturation, value and a
// changed flag (0 when the sample equals the previous one)
// path: a repeated color and black go straight to the done state; gray
// runs the saturation division; any other color runs the saturation
// division, then the hue division and a hue finishing step
// throughput: one item at a time, so a new input is taken only once the
// previous item is through; both quotients come from a single restoring divider
// that produces one quotient bit per cycle
// the output sits in a register of its own, so the next input transfer is
// taken while a result still waits for out_ready; a finished result that
// finds the output register full waits until the receiver takes it
// reset clears the stored color and result to zero (black, hue 0, sat 0)
// and leaves the block idle with no output pending
module rgb_to_hsv_convert #(
  parameter int HUE_FRAC_BITS = rgb2hsv_pkg::HUE_FRAC_DEF,
  parameter int SAT_FRAC_BITS = rgb2hsv_pkg::SAT_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rgb2hsv_pkg::CH_W-1:0]    in_red_in,
  input  logic [rgb2hsv_pkg::CH_W-1:0]    in_green_in,
  input  logic [rgb2hsv_pkg::CH_W-1:0]    in_blue_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rgb2hsv_pkg::HUE_W-1:0]   out_hue_out,
  output logic [rgb2hsv_pkg::SAT_W-1:0]   out_sat_out,
  output logic [rgb2hsv_pkg::VAL_W-1:0]   out_val_out,
  output logic                            out_changed
);
  import rgb2hsv_pkg::*;

  // quotient width covers the larger fraction plus the integer bit
  localparam int QW = ((HUE_FRAC_BITS > SAT_FRAC_BITS) ? HUE_FRAC_BITS : SAT_FRAC_BITS) + 1;
  localparam int CW = $clog2(QW);
  // hue before truncation to the field: below 8 << HUE_FRAC_BITS
  localparam int HW = HUE_FRAC_BITS + 3;
  localparam int RW = CH_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SAT  = 3'd1;
  localparam logic [2:0] ST_HUE  = 3'd2;
  localparam logic [2:0] ST_HFIN = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [3*CH_W-1:0]   last_color_r, last_color_nxt;
  logic [HUE_W-1:0]    last_hue_r, last_hue_nxt;
  logic [SAT_W-1:0]    last_sat_r, last_sat_nxt;
  logic [VAL_W-1:0]    last_val_r, last_val_nxt;
  logic                chg_r, chg_nxt;

  // divider and operand registers
  logic [RW-1:0]       rem_r, rem_nxt;
  logic [CH_W-1:0]     div_r, div_nxt;
  logic [QW-1:0]       quo_r, quo_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  chan_t               dif_r, dif_nxt;
  chan_t               mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  sector_t             sec_r, sec_nxt;

  // output register
  logic                ovld_r, ovld_nxt;
  logic [HUE_W-1:0]    ohue_r, ohue_nxt;
  logic [SAT_W-1:0]    osat_r, osat_nxt;
  logic [VAL_W-1:0]    oval_r, oval_nxt;
  logic                ochg_r, ochg_nxt;

  // input side comparisons
  logic [3*CH_W-1:0]   color;
  chan_t               mx, mn, opa, opb;
  sector_t             sec_in;
  logic                in_xfer;

  // divider step
  logic [RW-1:0]       trial, diff;
  logic                ge;

  // hue assembly
  logic [HW-1:0]       qh, hbase, hsum;

  assign color   = {in_red_in, in_green_in, in_blue_in};
  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    mx = (in_red_in > in_green_in) ? in_red_in : in_green_in;
    if (in_blue_in > mx) begin
      mx = in_blue_in;
    end
    mn = (in_red_in < in_green_in) ? in_red_in : in_green_in;
    if (in_blue_in < mn) begin
      mn = in_blue_in;
    end
    // red wins ties over green, green over blue
    priority if (mx == in_red_in) begin
      sec_in = SEC_RED;
      opa    = in_green_in;
      opb    = in_blue_in;
    end else if (mx == in_green_in) begin
      sec_in = SEC_GREEN;
      opa    = in_blue_in;
      opb    = in_red_in;
    end else begin
      sec_in = SEC_BLUE;
      opa    = in_red_in;
      opb    = in_green_in;
    end
  end

  // restoring step: the first step compares without a shift
  always_comb begin
    trial = (cnt_r == '0) ? rem_r : {rem_r[RW-2:0], 1'b0};
    ge    = (trial >= {1'b0, div_r});
    diff  = trial - {1'b0, div_r};
  end

  always_comb begin
    qh    = HW'(quo_r);
    unique case (sec_r)
      SEC_GREEN: hbase = HW'(2) << HUE_FRAC_BITS;
      SEC_BLUE:  hbase = HW'(4) << HUE_FRAC_BITS;
      default:   hbase = '0;
    endcase
    hsum = neg_r ? (hbase - qh) : (hbase + qh);
    // negative red hue wraps by a full circle
    if ((sec_r == SEC_RED) && neg_r && (qh != '0)) begin
      hsum = hsum + (HW'(6) << HUE_FRAC_BITS);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    last_color_nxt = last_color_r;
    last_hue_nxt   = last_hue_r;
    last_sat_nxt   = last_sat_r;
    last_val_nxt   = last_val_r;
    chg_nxt        = chg_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    dif_nxt        = dif_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    sec_nxt        = sec_r;
    ovld_nxt       = ovld_r;
    ohue_nxt       = ohue_r;
    osat_nxt       = osat_r;
    oval_nxt       = oval_r;
    ochg_nxt       = ochg_r;

    if (ovld_r && out_ready) begin
      ovld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_DONE;
          if (color == last_color_r) begin
            chg_nxt = 1'b0;
          end else begin
            chg_nxt        = 1'b1;
            last_color_nxt = color;
            last_val_nxt   = mx;
            dif_nxt        = mx - mn;
            neg_nxt        = (opa < opb);
            mag_nxt        = (opa < opb) ? (opb - opa) : (opa - opb);
            sec_nxt        = sec_in;
            // black keeps hue and saturation
            if (mx != '0) begin
              state_nxt = ST_SAT;
              rem_nxt   = RW'(mx - mn);
              div_nxt   = mx;
              quo_nxt   = '0;
              cnt_nxt   = '0;
            end
          end
        end
      end
      ST_SAT, ST_HUE: begin
        rem_nxt = ge ? diff : trial;
        quo_nxt = {quo_r[QW-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if ((state_r == ST_SAT) && (cnt_r == CW'(SAT_FRAC_BITS))) begin
          last_sat_nxt = SAT_W'(quo_nxt);
          // gray keeps hue
          if (dif_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_HUE;
            rem_nxt   = RW'(mag_r);
            div_nxt   = dif_r;
            quo_nxt   = '0;
            cnt_nxt   = '0;
          end
        end else if ((state_r == ST_HUE) && (cnt_r == CW'(HUE_FRAC_BITS))) begin
          state_nxt = ST_HFIN;
        end
      end
      ST_HFIN: begin
        last_hue_nxt = HUE_W'(hsum);
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // load the output register once it is free
        if (!ovld_r || out_ready) begin
          ovld_nxt  = 1'b1;
          ohue_nxt  = last_hue_r;
          osat_nxt  = last_sat_r;
          oval_nxt  = last_val_r;
          ochg_nxt  = chg_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_color_r <= '0;
      last_hue_r   <= '0;
      last_sat_r   <= '0;
      last_val_r   <= '0;
      ovld_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_color_r <= last_color_nxt;
      last_hue_r   <= last_hue_nxt;
      last_sat_r   <= last_sat_nxt;
      last_val_r   <= last_val_nxt;
      ovld_r       <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chg_r  <= chg_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    cnt_r  <= cnt_nxt;
    dif_r  <= dif_nxt;
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    sec_r  <= sec_nxt;
    ohue_r <= ohue_nxt;
    osat_r <= osat_nxt;
    oval_r <= oval_nxt;
    ochg_r <= ochg_nxt;
  end

  assign out_valid   = ovld_r;
  assign out_hue_out = ohue_r;
  assign out_sat_out = osat_r;
  assign out_val_out = oval_r;
  assign out_changed = ochg_r;

  // a new result only ever comes from the done state
  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovld_r) |-> $past(state_r == ST_DONE))
    else $error("output loaded outside done state");

  // an input transfer always starts work
  a_xfer_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r != ST_IDLE))
    else $error("input transfer left block idle");

  // partial remainder stays below the divisor once the first step is done
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SAT) || (state_r == ST_HUE)) && (cnt_r != '0)
      |-> (rem_r < {1'b0, div_r}))
    else $error("divider remainder out of range");

  // divisor is never zero while dividing
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SAT) || (state_r == ST_HUE)) |-> (div_r != '0))
    else $error("divide by zero");

endmodule
